// ===== hw/rtl/assert_macros.svh =====
// Assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SSI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SSI_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SSI_ASSERT(label, prop, msg)

`define SSI_ASSERT_NEVER(label, expr, msg)

`endif

`endif

// ===== hw/rtl/ssi_pkg.sv =====
package ssi_pkg;

  localparam logic [1:0] ACT_FIND   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [KEY_W-1:0] key;
  } ssi_in_t;

  typedef struct packed {
    logic               present;
    logic               status;
    logic [COUNT_W-1:0] count;
  } ssi_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_SH_RD,
    ST_SH_WR
  } ssi_state_t;

endpackage

// ===== hw/rtl/ssi_ram.sv =====
module ssi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/sorted_integer_set.sv =====
// Bounded sorted set of signed 32-bit keys with find, insert and remove.
// An operation is taken when start is high and busy is low; busy then stays
// high until the result, which appears on out_item for exactly one cycle
// with out_valid high. The receiver cannot stall, so every result must be
// captured in that cycle. Keys live in one RAM with a registered read, and
// that single read port sets the timing: each binary-search probe visits
// ST_SRCH and then ST_CMP, with at most ceil(log2(count+1)) probes before
// a find ends. An insert or remove that changes the set then moves every
// key above the position by one slot, each with a read in ST_SH_RD and a
// write in ST_SH_WR. No clearing pass is needed after reset.
`include "assert_macros.svh"

module sorted_integer_set
  import ssi_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ssi_in_t  in_item,
  output logic     out_valid,
  output ssi_out_t out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  ssi_state_t              state_r, state_nxt;
  logic [CW-1:0]           lo_r, lo_nxt;
  logic [CW-1:0]           hi_r, hi_nxt;
  logic [CW-1:0]           mid_r, mid_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [1:0]              act_r, act_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    eq_r, eq_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ssi_out_t                out_r, out_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  logic [CW-1:0]    mid;

  ssi_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    idx_r <= idx_nxt;
    act_r <= act_nxt;
    key_r <= key_nxt;
    eq_r  <= eq_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    eq_nxt        = eq_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = mid[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt   = in_item.action;
          key_nxt   = in_item.key;
          lo_nxt    = '0;
          hi_nxt    = cnt_r;
          eq_nxt    = 1'b0;
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid;
          state_nxt = ST_CMP;
        end else begin
          out_nxt.present = eq_r;
          out_nxt.status  = 1'b0;
          if (act_r == ACT_INSERT && !eq_r && cnt_r < CW'(CAPACITY)) begin
            idx_nxt   = cnt_r;
            state_nxt = ST_SH_RD;
          end else if (act_r == ACT_REMOVE && eq_r) begin
            idx_nxt   = lo_r;
            state_nxt = ST_SH_RD;
          end else begin
            out_nxt.status = (act_r == ACT_INSERT) && !eq_r;
            out_nxt.count  = COUNT_W'(cnt_r);
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      ST_CMP: begin
        if ($signed(ram_rdata) < key_r) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
          eq_nxt = ($signed(ram_rdata) == key_r);
        end
        state_nxt = ST_SRCH;
      end
      ST_SH_RD: begin
        if (act_r == ACT_INSERT) begin
          ram_raddr = AW'(idx_r - CW'(1));
          if (idx_r > lo_r) begin
            state_nxt = ST_SH_WR;
          end else begin
            ram_we        = 1'b1;
            ram_waddr     = lo_r[AW-1:0];
            ram_wdata     = key_r;
            cnt_nxt       = cnt_r + CW'(1);
            out_nxt.count = COUNT_W'(cnt_r + CW'(1));
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          ram_raddr = AW'(idx_r + CW'(1));
          if (idx_r + CW'(1) < cnt_r) begin
            state_nxt = ST_SH_WR;
          end else begin
            cnt_nxt       = cnt_r - CW'(1);
            out_nxt.count = COUNT_W'(cnt_r - CW'(1));
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_SH_WR: begin
        ram_we = 1'b1;
        if (act_r == ACT_INSERT) begin
          idx_nxt = idx_r - CW'(1);
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
        state_nxt = ST_SH_RD;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `SSI_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted item did not raise busy")
  `SSI_ASSERT(a_result_end, out_valid |-> !busy && $past(busy), "result outside end of work")
  `SSI_ASSERT_NEVER(a_count_cap, cnt_r > CW'(CAPACITY), "count above capacity")
  `SSI_ASSERT_NEVER(a_full_present, out_valid && out_item.status && out_item.present,
                    "full flag on a present key")

endmodule
